// ===== sv/lsqf_pkg.sv =====
package lsqf_pkg;

    // Largest number of points held in one set; further points are dropped.
    localparam int MAX_POINTS = 1024;
    localparam int LOG_N      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Widths of the running sums, from the Q8.8 input range and the point limit.
    localparam int SX_W  = 16 + LOG_N;
    localparam int SXX_W = 31 + LOG_N;
    localparam int SXY_W = 32 + LOG_N;

    // Shared datapath widths: multiplier operand, denominator, remainder, accumulator.
    localparam int MPL_W  = SX_W + 1;
    localparam int DEN_W  = 2 * SX_W - 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int ACC_W  = SXY_W + SX_W + 12;
    localparam int STEP_W = $clog2(ACC_W);
    localparam int Q_W    = 33;

    // Numerator scaling that turns the quotients into Q16.16.
    localparam int SLOPE_SHIFT = 16;
    localparam int ICPT_SHIFT  = 8;

    // Fit status codes.
    localparam logic [1:0] FIT_OK         = 2'd0;
    localparam logic [1:0] FIT_DEGENERATE = 2'd1;
    localparam logic [1:0] FIT_SATURATED  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [1:0]         fit_status;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]        point_count;
        logic signed [SX_W-1:0]  sum_of_x;
        logic signed [SX_W-1:0]  sum_of_y;
        logic [SXX_W-1:0]        sum_of_x_squared;
        logic signed [SXY_W-1:0] sum_of_x_times_y;
    } t_sums;

    typedef struct packed {
        logic idle;
        logic done;
    } t_solve_stat;

endpackage

// ===== sv/lsqf_addsub.sv =====
// Shared adder/subtractor used for every multiply step, the magnitude negation and every divide step.
module lsqf_addsub (
    input  logic [lsqf_pkg::ACC_W-1:0] i_a,
    input  logic [lsqf_pkg::ACC_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [lsqf_pkg::ACC_W-1:0] o_y
);

    logic [lsqf_pkg::ACC_W-1:0] w_b;

    // Subtraction as addition of the inverted operand plus one.
    assign w_b = i_sub ? ~i_b : i_b;
    assign o_y = i_a + w_b + lsqf_pkg::ACC_W'(i_sub);

endmodule

// ===== sv/lsqf_accum.sv =====
// Running sums over the points of one set, one point per cycle while i_accept is high.
module lsqf_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_clear,
    input  lsqf_pkg::t_in_item i_item,
    output lsqf_pkg::t_sums    o_sums
);

    lsqf_pkg::t_sums    r_sums;
    logic signed [31:0] w_xx;
    logic signed [31:0] w_xy;
    logic               w_room;

    // Point products; x*x is never negative and fits in 31 bits.
    assign w_xx   = i_item.x_value * i_item.x_value;
    assign w_xy   = i_item.x_value * i_item.y_value;
    assign w_room = r_sums.point_count < lsqf_pkg::CNT_W'(lsqf_pkg::MAX_POINTS);

    // Accumulate while there is room; points past the limit are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sums <= '0;
        end else if (i_accept && w_room) begin
            r_sums.point_count      <= r_sums.point_count + lsqf_pkg::CNT_W'(1);
            r_sums.sum_of_x         <= r_sums.sum_of_x + lsqf_pkg::SX_W'(i_item.x_value);
            r_sums.sum_of_y         <= r_sums.sum_of_y + lsqf_pkg::SX_W'(i_item.y_value);
            r_sums.sum_of_x_squared <= r_sums.sum_of_x_squared
                                       + lsqf_pkg::SXX_W'(w_xx[30:0]);
            r_sums.sum_of_x_times_y <= r_sums.sum_of_x_times_y + lsqf_pkg::SXY_W'(w_xy);
        end
    end

    assign o_sums = r_sums;

endmodule

// ===== sv/lsqf_solve.sv =====
// Sequencer that forms the determinant and both numerators by shift-and-add
// multiplication and then divides by restoring division, all through one adder.
module lsqf_solve (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    input  lsqf_pkg::t_sums       i_sums,
    output lsqf_pkg::t_solve_stat o_stat,
    output lsqf_pkg::t_out_item   o_result
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_NEXT = 8'b0000_1000,
        S_MAG  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // Products in order; an odd product is subtracted from the even one before it.
    localparam logic [2:0] OP_N_SXX  = 3'd0;
    localparam logic [2:0] OP_SX_SX  = 3'd1;
    localparam logic [2:0] OP_N_SXY  = 3'd2;
    localparam logic [2:0] OP_SX_SY  = 3'd3;
    localparam logic [2:0] OP_SXX_SY = 3'd4;
    localparam logic [2:0] OP_SXY_SX = 3'd5;

    localparam int ACC_W = lsqf_pkg::ACC_W;
    localparam int MPL_W = lsqf_pkg::MPL_W;
    localparam int REM_W = lsqf_pkg::REM_W;
    localparam int Q_W   = lsqf_pkg::Q_W;

    t_state                       r_state;
    t_state                       n_state;
    logic [2:0]                   r_op;
    logic [lsqf_pkg::STEP_W-1:0]  r_cnt;
    logic [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]             r_mcand;
    logic [MPL_W-1:0]             r_mplier;
    logic                         r_sub;
    logic [lsqf_pkg::DEN_W-1:0]   r_den;
    logic [ACC_W-1:0]             r_num;
    logic [REM_W-1:0]             r_rem;
    logic [Q_W-1:0]               r_quo;
    logic                         r_ovf;
    logic                         r_neg;
    logic                         r_sat;
    lsqf_pkg::t_out_item          r_result;

    logic [ACC_W-1:0]             w_add_a;
    logic [ACC_W-1:0]             w_add_b;
    logic                         w_add_sub;
    logic [ACC_W-1:0]             w_add_y;
    logic [REM_W-1:0]             w_rem_shift;
    logic                         w_fits;
    logic                         w_mul_end;
    logic                         w_div_end;
    logic [ACC_W-1:0]             w_mag;
    logic [Q_W-1:0]               w_limit;
    logic                         w_fin_sat;
    logic [31:0]                  w_fin_val;

    // Step ends and divide-step helpers.
    assign w_mul_end   = r_cnt == lsqf_pkg::STEP_W'(MPL_W - 1);
    assign w_div_end   = r_cnt == lsqf_pkg::STEP_W'(ACC_W - 1);
    assign w_rem_shift = {r_rem[REM_W-2:0], r_num[ACC_W-1]};
    assign w_fits      = !w_add_y[ACC_W-1];
    assign w_mag       = r_acc[ACC_W-1] ? w_add_y : r_acc;

    // Operand selection for the shared adder.
    always_comb begin
        unique case (r_state)
            S_MAG: begin
                w_add_a   = '0;
                w_add_b   = r_acc;
                w_add_sub = 1'b1;
            end
            S_DIV: begin
                w_add_a   = ACC_W'(w_rem_shift);
                w_add_b   = ACC_W'(r_den);
                w_add_sub = 1'b1;
            end
            default: begin
                // The top multiplier bit carries negative weight.
                w_add_a   = r_acc;
                w_add_b   = r_mcand;
                w_add_sub = r_sub ^ w_mul_end;
            end
        endcase
    end

    lsqf_addsub u_addsub (
        .i_a   (w_add_a),
        .i_b   (w_add_b),
        .i_sub (w_add_sub),
        .o_y   (w_add_y)
    );

    // Saturate the quotient magnitude and apply the sign.
    assign w_limit   = r_neg ? {2'b01, {(Q_W - 2){1'b0}}} : {2'b00, {(Q_W - 2){1'b1}}};
    assign w_fin_sat = r_ovf || (r_quo > w_limit);
    always_comb begin
        priority if (w_fin_sat) begin
            w_fin_val = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_neg) begin
            w_fin_val = 32'd0 - r_quo[31:0];
        end else begin
            w_fin_val = r_quo[31:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL: begin
                if (w_mul_end) n_state = r_op[0] ? S_NEXT : S_LOAD;
            end
            S_NEXT: begin
                if (r_op == OP_SX_SX) begin
                    n_state = (r_acc == '0) ? S_DONE : S_LOAD;
                end else begin
                    n_state = S_MAG;
                end
            end
            S_MAG: n_state = S_DIV;
            S_DIV: if (w_div_end) n_state = S_FIN;
            S_FIN: n_state = (r_op == OP_SX_SY) ? S_LOAD : S_DONE;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op  <= OP_N_SXX;
                r_sat <= 1'b0;
            end
            S_LOAD: begin
                r_cnt <= '0;
                r_sub <= r_op[0];
                if (!r_op[0]) r_acc <= '0;
                unique case (r_op)
                    OP_N_SXX: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x_squared);
                        r_mplier <= MPL_W'(i_sums.point_count);
                    end
                    OP_SX_SX: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x);
                        r_mplier <= MPL_W'(i_sums.sum_of_x);
                    end
                    OP_N_SXY: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x_times_y);
                        r_mplier <= MPL_W'(i_sums.point_count);
                    end
                    OP_SX_SY: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x);
                        r_mplier <= MPL_W'(i_sums.sum_of_y);
                    end
                    OP_SXX_SY: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x_squared);
                        r_mplier <= MPL_W'(i_sums.sum_of_y);
                    end
                    default: begin
                        r_mcand  <= ACC_W'(i_sums.sum_of_x_times_y);
                        r_mplier <= MPL_W'(i_sums.sum_of_x);
                    end
                endcase
            end
            S_MUL: begin
                if (r_mplier[0]) r_acc <= w_add_y;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + lsqf_pkg::STEP_W'(1);
                if (w_mul_end && !r_op[0]) r_op <= r_op + 3'd1;
            end
            S_NEXT: begin
                if (r_op == OP_SX_SX) begin
                    r_den <= r_acc[lsqf_pkg::DEN_W-1:0];
                    r_op  <= OP_N_SXY;
                    if (r_acc == '0) begin
                        r_result.slope      <= '0;
                        r_result.intercept  <= '0;
                        r_result.fit_status <= lsqf_pkg::FIT_DEGENERATE;
                    end
                end
            end
            S_MAG: begin
                r_neg <= r_acc[ACC_W-1];
                r_num <= (r_op == OP_SX_SY) ? (w_mag << lsqf_pkg::SLOPE_SHIFT)
                                            : (w_mag << lsqf_pkg::ICPT_SHIFT);
                r_rem <= '0;
                r_quo <= '0;
                r_ovf <= 1'b0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_fits ? w_add_y[REM_W-1:0] : w_rem_shift;
                r_quo <= {r_quo[Q_W-2:0], w_fits};
                r_ovf <= r_ovf | r_quo[Q_W-1];
                r_num <= r_num << 1;
                r_cnt <= r_cnt + lsqf_pkg::STEP_W'(1);
            end
            S_FIN: begin
                if (r_op == OP_SX_SY) begin
                    r_result.slope <= w_fin_val;
                    r_sat          <= w_fin_sat;
                    r_op           <= OP_SXX_SY;
                end else begin
                    r_result.intercept  <= w_fin_val;
                    r_result.fit_status <= (r_sat || w_fin_sat) ? lsqf_pkg::FIT_SATURATED
                                                                : lsqf_pkg::FIT_OK;
                end
            end
            S_DONE: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_stat.idle = r_state == S_IDLE;
    assign o_stat.done = r_state == S_DONE;
    assign o_result    = r_result;

endmodule

// ===== sv/least_squares_line_fit.sv =====
// Points are taken one per cycle while the input is ready; each is added to the running sums in that cycle.
// A point marked last starts the fit: six shift-and-add products and two
// 80-step divisions on one shared adder (only two products if degenerate),
// and the result then waits until a full output register has been emptied.
// The input is not ready during the fit; it becomes ready again once the result is in the
// output register. Reset (synchronous, active low) clears the sums, sequencer and output valid flag.
module least_squares_line_fit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsqf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsqf_pkg::t_out_item o_out_item
);

    lsqf_pkg::t_sums       w_sums;
    lsqf_pkg::t_solve_stat w_stat;
    lsqf_pkg::t_out_item   w_result;
    lsqf_pkg::t_out_item   r_out_item;
    logic                  r_out_valid;
    logic                  w_accept;
    logic                  w_start;
    logic                  w_out_free;
    logic                  w_clear;

    // Handshake and hand-over between the solver and the output register.
    assign o_in_ready = w_stat.idle;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && i_in_item.last_point;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_clear    = w_stat.done && w_out_free;

    lsqf_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_clear  (w_clear),
        .i_item   (i_in_item),
        .o_sums   (w_sums)
    );

    lsqf_solve u_solve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_sums     (w_sums),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    // Output register holds one finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) r_out_item <= w_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted last point must close the input.
    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_in_ready)
        else $error("input still ready after the last point of a set");

    // A new result only appears when the solver had one finished.
    a_result_from_solver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_stat.done))
        else $error("result appeared without a finished fit");

    // The point count never passes the limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sums.point_count <= lsqf_pkg::CNT_W'(lsqf_pkg::MAX_POINTS))
        else $error("point count beyond the limit");

    // A degenerate fit reports zero slope and intercept.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.fit_status == lsqf_pkg::FIT_DEGENERATE))
        |-> (o_out_item.slope == '0 && o_out_item.intercept == '0))
        else $error("degenerate fit with non-zero result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Random sets are sent until this many points have been sent in all.
    localparam int RANDOM_ITEMS = 1730;

    // Typed-in expectations for the directed table.
    localparam logic signed [31:0] SLOPE_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

    typedef struct packed {
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic                last;
        logic                typed;
        lsqf_pkg::t_out_item res;
    } t_plan_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    lsqf_pkg::t_in_item  in_item     = '0;
    logic                out_ready   = 1'b0;
    logic                in_ready;
    logic                out_valid;
    lsqf_pkg::t_out_item out_item;

    // Predictor state: running sums of the set being collected.
    int unsigned     held_points = 0;
    longint          sum_x       = 0;
    longint          sum_y       = 0;
    longint unsigned sum_xx      = 0;
    longint          sum_xy      = 0;

    lsqf_pkg::t_out_item pending_fits [$];
    t_plan_row           plan [$];
    int unsigned         mismatch_count = 0;
    int unsigned         points_sent    = 0;
    bit                  send_burst     = 1'b0;
    bit                  recv_burst     = 1'b0;
    lsqf_pkg::t_out_item want;

    least_squares_line_fit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Saturates a wide quotient to 32 signed bits; the top bit flags a clamp.
    function automatic logic [32:0] clamp_quotient(input logic signed [127:0] v);
        if (v > 128'sd2147483647) begin
            return {1'b1, Q_MAX};
        end else if (v < -128'sd2147483648) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Adds one point to the sums and, on the last point, works out the line fit.
    task automatic absorb_point(input lsqf_pkg::t_in_item p, output bit fitted,
                                output lsqf_pkg::t_out_item r);
        longint             xv;
        longint             yv;
        logic signed [127:0] n_w, sx_w, sy_w, sxx_w, sxy_w, den, num_s, num_i;
        logic [32:0]        qs, qi;
        xv = p.x_value;
        yv = p.y_value;
        fitted = 1'b0;
        r = '0;
        if (held_points < lsqf_pkg::MAX_POINTS) begin
            held_points++;
            sum_x  += xv;
            sum_y  += yv;
            sum_xx += longint'(xv * xv);
            sum_xy += xv * yv;
        end
        if (p.last_point) begin
            fitted = 1'b1;
            n_w   = held_points;
            sx_w  = sum_x;
            sy_w  = sum_y;
            sxx_w = sum_xx;
            sxy_w = sum_xy;
            den   = n_w * sxx_w - sx_w * sx_w;
            if (den == 0) begin
                r.fit_status = lsqf_pkg::FIT_DEGENERATE;
            end else begin
                num_s = (n_w * sxy_w - sx_w * sy_w) <<< 16;
                num_i = (sxx_w * sy_w - sxy_w * sx_w) <<< 8;
                qs = clamp_quotient(num_s / den);
                qi = clamp_quotient(num_i / den);
                r.slope      = qs[31:0];
                r.intercept  = qi[31:0];
                r.fit_status = (qs[32] || qi[32]) ? lsqf_pkg::FIT_SATURATED
                                                  : lsqf_pkg::FIT_OK;
            end
            held_points = 0;
            sum_x  = 0;
            sum_y  = 0;
            sum_xx = 0;
            sum_xy = 0;
        end
    endtask

    // Offers one point, called and returning at a falling edge.
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input bit last, input bit typed,
                              input lsqf_pkg::t_out_item typed_res);
        int unsigned         gap;
        lsqf_pkg::t_in_item  p;
        bit                  fitted;
        lsqf_pkg::t_out_item r;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        p.x_value    = x;
        p.y_value    = y;
        p.last_point = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        absorb_point(p, fitted, r);
        if (fitted) begin
            if (typed) r = typed_res;
            pending_fits = {pending_fits, r};
        end
        points_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic signed [15:0] x, input logic signed [15:0] y,
                           input bit last, input bit typed, input logic signed [31:0] slope,
                           input logic signed [31:0] icpt, input logic [1:0] status);
        t_plan_row row;
        row.x     = x;
        row.y     = y;
        row.last  = last;
        row.typed = typed;
        row.res   = '{slope: slope, intercept: icpt, fit_status: status};
        plan = {plan, row};
    endtask

    // Draws one coordinate, favouring the extremes and small magnitudes.
    function automatic logic signed [15:0] draw_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one set of points of the given shape and length.
    task automatic send_set(input int unsigned len, input int shape);
        logic signed [15:0] common_x, x, y;
        int                 gain, offset, t;
        int unsigned        k;
        common_x = draw_coord();
        gain     = $signed($urandom_range(0, 1024)) - 512;
        offset   = $signed($urandom_range(0, 4095)) - 2048;
        for (k = 0; k < len; k++) begin
            case (shape)
                0: x = common_x;
                3: x = ($urandom_range(0, 3) != 0) ? 16'sh8000 : draw_coord();
                default: x = draw_coord();
            endcase
            if (shape == 1 || shape == 3) begin
                y = draw_coord();
            end else begin
                t = ((gain * int'(x)) >>> 8) + offset + $signed($urandom_range(0, 63)) - 32;
                y = t[15:0];
            end
            send_point(x, y, k == len - 1, 1'b0, '0);
        end
    endtask

    // Stimulus: reset, directed table, then random sets.
    initial begin
        int unsigned i;
        int unsigned pick;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // x, y, last, typed, slope, intercept, status
        add_row(16'sd0,     16'sd0,     1, 1, 32'sd0, 32'sd0, lsqf_pkg::FIT_DEGENERATE);
        add_row(16'sh8000,  16'sh7FFF,  1, 1, 32'sd0, 32'sd0, lsqf_pkg::FIT_DEGENERATE);
        add_row(16'sd0,     16'sd0,     0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd256,   16'sd256,   1, 1, SLOPE_ONE, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd0,     16'sh8000,  0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd1,     16'sh7FFF,  1, 1, Q_MAX, -32'sd8388608, lsqf_pkg::FIT_SATURATED);
        add_row(16'sd0,     16'sh7FFF,  0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd1,     16'sh8000,  1, 1, Q_MIN, 32'sd8388352, lsqf_pkg::FIT_SATURATED);
        add_row(16'sd100,   16'sd5,     0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd100,   -16'sd7,    0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd100,   16'sh7FFF,  1, 1, 32'sd0, 32'sd0, lsqf_pkg::FIT_DEGENERATE);
        add_row(16'sh8000,  16'sh8000,  0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sh7FFF,  16'sh7FFF,  0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sh8000,  16'sh7FFF,  0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sh7FFF,  16'sh8000,  1, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sh8000,  16'sd0,     0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sh7FFF,  16'sd0,     1, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd256,   16'sd512,   0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(16'sd512,   16'sd768,   0, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);
        add_row(-16'sd256,  -16'sd1,    1, 0, 32'sd0, 32'sd0, lsqf_pkg::FIT_OK);

        for (i = 0; i < plan.size(); i++) begin
            send_point(plan[i].x, plan[i].y, plan[i].last, plan[i].typed, plan[i].res);
        end

        // One set that reaches the point limit and may run past it, so that any tail is dropped.
        send_set(lsqf_pkg::MAX_POINTS + $urandom_range(0, 12), 3);

        // Mostly line-like sets, with degenerate, noisy and longer ones mixed in.
        while (points_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_set($urandom_range(1, 5), 0);
            end else if (pick < 13) begin
                send_set($urandom_range(20, 100), 2);
            end else if (pick < 25) begin
                send_set($urandom_range(1, 8), 1);
            end else begin
                send_set($urandom_range(2, 10), 2);
            end
        end
        in_valid <= 1'b0;

        wait (pending_fits.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: random stalls between items, with stretches of none.
    initial begin
        int unsigned gap;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compares each accepted result with the oldest expected fit.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_fits.size() == 0) begin
                $error("fit result with no point set pending");
                mismatch_count++;
            end else begin
                want = pending_fits.pop_front();
                if (out_item.slope !== want.slope) begin
                    $error("slope: expected %0d, actual %0d", want.slope, out_item.slope);
                    mismatch_count++;
                end
                if (out_item.intercept !== want.intercept) begin
                    $error("intercept: expected %0d, actual %0d",
                           want.intercept, out_item.intercept);
                    mismatch_count++;
                end
                if (out_item.fit_status !== want.fit_status) begin
                    $error("fit_status: expected %0d, actual %0d",
                           want.fit_status, out_item.fit_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
